/* hdl/egrd_pkg.sv */
package egrd_pkg;

    localparam int BYTE_BITS = 8;
    localparam int RUN_BITS  = 16;
    localparam int LEN_W     = 16;
    localparam int ACC_W     = RUN_BITS;
    localparam int CNT_W     = $clog2(RUN_BITS + 1);
    localparam int CMP_W     = (ACC_W > LEN_W) ? ACC_W : LEN_W;
    localparam int SEL_W     = $clog2(BYTE_BITS);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_IMAGE_PIXELS = 3'd0;
    localparam logic [LEN_W-1:0]      IMAGE_PIXELS_RST  = 16'hFFFF;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic             colour;
        logic             len_phase;
        logic [CNT_W-1:0] bits_left;
        logic [ACC_W-1:0] run_accum;
        logic             skip;
    } t_dec_state;

    // One decoded run
    typedef struct packed {
        logic             colour;
        logic [LEN_W-1:0] length;
        logic             error;
    } t_run;

endpackage

/* hdl/egrd_decode.sv */
module egrd_decode (
    input  egrd_pkg::t_dec_state                          i_state,
    input  logic [egrd_pkg::BYTE_BITS-1:0]                i_data_byte,
    input  logic                                          i_segment_start,
    input  logic [egrd_pkg::LEN_W-1:0]                    i_image_pixels,
    output egrd_pkg::t_dec_state                          o_state,
    output egrd_pkg::t_run [egrd_pkg::BYTE_BITS-1:0]      o_lanes,
    output logic [egrd_pkg::BYTE_BITS-1:0]                o_lane_valid
);
    import egrd_pkg::*;

    t_dec_state st;
    logic       bit_v;
    logic       fin;

    // One lane per bit position; each bit completes at most one run.
    always_comb begin
        st           = i_state;
        bit_v        = 1'b0;
        fin          = 1'b0;
        o_lanes      = '0;
        o_lane_valid = '0;
        if (i_segment_start) begin
            st           = '0;
            st.colour    = i_data_byte[0];
        end
        for (int b = 0; b < BYTE_BITS; b++) begin
            fin   = 1'b0;
            bit_v = i_data_byte[b];
            if (!(i_segment_start && b == 0) && !st.skip) begin
                if (!st.len_phase) begin
                    if (bit_v) begin
                        st.len_phase = 1'b1;
                        st.run_accum = ACC_W'(1);
                        fin          = (st.bits_left == '0);
                    end else begin
                        st.bits_left = st.bits_left + CNT_W'(1);
                        if (st.bits_left >= CNT_W'(RUN_BITS)) begin
                            // prefix overflow: flag and drop the segment
                            o_lane_valid[b]     = 1'b1;
                            o_lanes[b].colour   = st.colour;
                            o_lanes[b].length   = '0;
                            o_lanes[b].error    = 1'b1;
                            st.skip             = 1'b1;
                            st.len_phase        = 1'b0;
                            st.bits_left        = '0;
                            st.run_accum        = '0;
                        end
                    end
                end else begin
                    st.run_accum = {st.run_accum[ACC_W-2:0], bit_v};
                    if (st.bits_left != '0) begin
                        st.bits_left = st.bits_left - CNT_W'(1);
                    end
                    fin = (st.bits_left == '0);
                end
                if (fin) begin
                    o_lane_valid[b]   = 1'b1;
                    o_lanes[b].colour = st.colour;
                    if (CMP_W'(st.run_accum) > CMP_W'(i_image_pixels)) begin
                        o_lanes[b].length = '0;
                        o_lanes[b].error  = 1'b1;
                        st.skip           = 1'b1;
                    end else begin
                        o_lanes[b].length = LEN_W'(st.run_accum);
                        o_lanes[b].error  = 1'b0;
                        st.colour         = ~st.colour;
                    end
                    st.len_phase = 1'b0;
                    st.bits_left = '0;
                    st.run_accum = '0;
                end
            end
        end
        o_state = st;
    end

endmodule

/* hdl/elias_gamma_rle_bitmap_decoder_top.sv */
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_data_byte, i_segment_start
// out       output     o_out_valid / i_out_stall  o_run_colour, o_run_length,
//                                                 o_run_error, o_last_of_byte
// cfg       input      APB psel/penable/pready    image_pixels at byte address 0
//
// A byte is held in an input register, decoded combinationally across all eight
// bit positions, and its runs land in an eight-slot run buffer.
// The buffer drains one run per cycle while the output is not stalled, so a byte's
// runs hold the output until its last run leaves; bytes producing at most one run go through at one per cycle.
// An accepted byte passes the input register and then the run buffer before its first run shows.
// Synchronous active-low reset clears decoder state, the buffer mask and
// image_pixels (to 65535).
// A stall on the output backs up through the run buffer into o_in_stall.
module elias_gamma_rle_bitmap_decoder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [egrd_pkg::BYTE_BITS-1:0]       i_data_byte,
    input  logic                                 i_segment_start,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_run_colour,
    output logic [egrd_pkg::LEN_W-1:0]           o_run_length,
    output logic                                 o_run_error,
    output logic                                 o_last_of_byte,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [egrd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [egrd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [egrd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import egrd_pkg::*;

    // configuration
    logic [LEN_W-1:0] r_image_pixels;

    // input register
    logic                 r_in_valid;
    logic [BYTE_BITS-1:0] r_in_byte;
    logic                 r_in_start;

    // decoder state
    t_dec_state r_state;
    t_dec_state n_state;

    // run buffer
    t_run                  r_buf [BYTE_BITS];
    logic [BYTE_BITS-1:0]  r_buf_mask;
    t_run [BYTE_BITS-1:0]  lanes;
    logic [BYTE_BITS-1:0]  lane_valid;

    logic             in_accept;
    logic             out_pop;
    logic             buf_free;
    logic             dec_fire;
    logic [SEL_W-1:0] sel;
    logic [BYTE_BITS-1:0] sel_onehot;
    logic [BYTE_BITS-1:0] rest_mask;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_IMAGE_PIXELS) ? CFG_DATA_W'(r_image_pixels) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_pixels <= IMAGE_PIXELS_RST;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_IMAGE_PIXELS) begin
            r_image_pixels <= pwdata[LEN_W-1:0];
        end
    end

    // ---------------- output selection ----------------
    // Drain the lowest pending lane first: lanes follow bit order.
    always_comb begin
        sel = '0;
        for (int i = BYTE_BITS - 1; i >= 0; i--) begin
            if (r_buf_mask[i]) begin
                sel = SEL_W'(i);
            end
        end
    end

    assign sel_onehot = BYTE_BITS'(1) << sel;
    assign rest_mask  = r_buf_mask & ~sel_onehot;

    assign o_out_valid    = |r_buf_mask;
    assign o_run_colour   = r_buf[sel].colour;
    assign o_run_length   = r_buf[sel].length;
    assign o_run_error    = r_buf[sel].error;
    assign o_last_of_byte = (rest_mask == '0);

    assign out_pop = o_out_valid && !i_out_stall;

    // Buffer can take a new byte when empty or when its last run leaves now.
    assign buf_free = (r_buf_mask == '0) || (out_pop && rest_mask == '0);
    assign dec_fire = r_in_valid && buf_free;

    // Input register is free when empty or when its byte is decoded now.
    assign o_in_stall = r_in_valid && !dec_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ---------------- decode ----------------
    egrd_decode u_decode (
        .i_state         (r_state),
        .i_data_byte     (r_in_byte),
        .i_segment_start (r_in_start),
        .i_image_pixels  (r_image_pixels),
        .o_state         (n_state),
        .o_lanes         (lanes),
        .o_lane_valid    (lane_valid)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_buf_mask <= '0;
        end else begin
            // hold a byte until the decoder takes it
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (dec_fire) begin
                r_in_valid <= 1'b0;
            end
            // advance decoder state once per decoded byte
            if (dec_fire) begin
                r_state    <= n_state;
                r_buf_mask <= lane_valid;
            end else if (out_pop) begin
                r_buf_mask <= rest_mask;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_segment_start;
        end
        if (dec_fire) begin
            for (int i = 0; i < BYTE_BITS; i++) begin
                r_buf[i] <= lanes[i];
            end
        end
    end

    // ---------------- assertions ----------------
    a_skip_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.skip |-> (!r_state.len_phase && r_state.bits_left == '0
                          && r_state.run_accum == '0))
        else $error("run state not cleared while skipping a segment");

    a_prefix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.len_phase |-> (r_state.bits_left < CNT_W'(RUN_BITS)))
        else $error("stored zero prefix reached the overflow limit");

    a_count_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.len_phase |-> (r_state.run_accum != '0))
        else $error("length phase with empty accumulator");

    a_error_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_error) |-> (o_run_length == '0))
        else $error("error run carries nonzero length");

    a_byte_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_byte) |=> o_out_valid)
        else $error("runs of a byte interrupted before its last run");

endmodule

/* verif/tb_elias_gamma_rle_bitmap_decoder_top.sv */
`timescale 1ns / 100ps

module tb_elias_gamma_rle_bitmap_decoder_top;
    import egrd_pkg::*;

    localparam int IDLE_PCT   = 35;
    localparam int STALL_PCT  = 35;
    localparam int PHASE_ITEMS = 85;
    localparam int HANG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    // The input register and decode stage can hold a byte that makes no run yet.
    localparam int SETTLE_CYCLES = 8;

    // One decoded run as seen on the output channel
    typedef struct packed {
        logic             colour;
        logic [LEN_W-1:0] length;
        logic             error;
        logic             last;
    } t_run_rec;

    // One directed transaction: optional image_pixels write first, optional pinned run
    typedef struct packed {
        logic [7:0]       data;
        logic             start;
        logic             wr_pix;
        logic [LEN_W-1:0] pix;
        logic             pin;
        t_run_rec         run;
    } t_stim_row;

    localparam t_run_rec NO_RUN = '0;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [BYTE_BITS-1:0]  i_data_byte;
    logic                  i_segment_start;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_run_colour;
    logic [LEN_W-1:0]      o_run_length;
    logic                  o_run_error;
    logic                  o_last_of_byte;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    elias_gamma_rle_bitmap_decoder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_segment_start (i_segment_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_run_colour    (o_run_colour),
        .o_run_length    (o_run_length),
        .o_run_error     (o_run_error),
        .o_last_of_byte  (o_last_of_byte),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Directed transactions. Pinned runs are the obvious ones: prefix overflow
    // right after reset, the longest legal run, run-too-long and restarts.
    t_stim_row plan [0:18] = '{
        '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'h00, 1'b0, 1'b0, 16'd0, 1'b1, '{1'b0, 16'd0, 1'b1, 1'b1}},
        '{8'hFF, 1'b0, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'h03, 1'b1, 1'b0, 16'd0, 1'b1, '{1'b1, 16'd1, 1'b0, 1'b1}},
        '{8'h00, 1'b1, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'hFF, 1'b0, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'hFF, 1'b0, 1'b0, 16'd0, 1'b1, '{1'b0, 16'hFFFF, 1'b0, 1'b1}},
        '{8'hFF, 1'b1, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'hAA, 1'b0, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'h55, 1'b1, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'h5A, 1'b0, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'h96, 1'b0, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'hFD, 1'b1, 1'b1, 16'd1, 1'b1, '{1'b1, 16'd0, 1'b1, 1'b1}},
        '{8'h03, 1'b1, 1'b0, 16'd0, 1'b1, '{1'b1, 16'd1, 1'b0, 1'b1}},
        '{8'hFF, 1'b1, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'h00, 1'b1, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0, NO_RUN},
        '{8'h00, 1'b0, 1'b0, 16'd1, 1'b1, '{1'b0, 16'd0, 1'b1, 1'b1}}
    };

    // Decoder shadow state
    logic [LEN_W-1:0] image_pixels;
    logic             dec_colour;
    logic             dec_len_phase;
    logic [CNT_W-1:0] dec_bits_left;
    logic [31:0]      dec_accum;
    logic             dec_skip;

    t_run_rec fresh_runs [$];
    t_run_rec pending_runs [$];
    t_run_rec got_run;
    t_run_rec want_run;
    int       bad_runs;
    int       phase_items;
    int       hang_cycles;
    logic     calm;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void clear_dec();
        dec_len_phase = 1'b0;
        dec_bits_left = '0;
        dec_accum     = '0;
    endfunction

    function automatic void close_run();
        if (dec_accum > {16'h0, image_pixels}) begin
            fresh_runs.push_back('{colour: dec_colour, length: '0, error: 1'b1, last: 1'b0});
            dec_skip = 1'b1;
        end else begin
            fresh_runs.push_back('{colour: dec_colour, length: dec_accum[LEN_W-1:0],
                                   error: 1'b0, last: 1'b0});
            dec_colour = ~dec_colour;
        end
        clear_dec();
    endfunction

    // Decode one byte LSB first into fresh_runs, advancing the shadow state
    function automatic void decode_byte(input logic [7:0] b, input logic s);
        int first;
        first = 0;
        fresh_runs.delete();
        if (s) begin
            dec_colour = b[0];
            dec_skip   = 1'b0;
            clear_dec();
            first = 1;
        end
        for (int i = first; i < BYTE_BITS; i++) begin
            if (dec_skip)
                break;
            if (!dec_len_phase) begin
                if (b[i]) begin
                    dec_len_phase = 1'b1;
                    dec_accum     = 32'd1;
                    if (dec_bits_left == 0)
                        close_run();
                end else begin
                    dec_bits_left++;
                    // Prefix too long for the counter: flag and skip the segment
                    if (dec_bits_left >= RUN_BITS) begin
                        fresh_runs.push_back('{colour: dec_colour, length: '0,
                                               error: 1'b1, last: 1'b0});
                        dec_skip = 1'b1;
                        clear_dec();
                    end
                end
            end else begin
                dec_accum = {dec_accum[30:0], b[i]};
                if (dec_bits_left > 0)
                    dec_bits_left--;
                if (dec_bits_left == 0)
                    close_run();
            end
        end
        if (fresh_runs.size() > 0)
            fresh_runs[fresh_runs.size()-1].last = 1'b1;
    endfunction

    // Drive one byte, wait for the transaction, then log what it must produce
    task automatic send_byte(input logic [7:0] b, input logic s, input logic pin,
                             input t_run_rec pinned);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid  <= 1'b0;
            i_data_byte <= BYTE_BITS'($urandom);
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_segment_start <= s;
        do @(posedge i_clk); while (o_in_stall);
        phase_items++;
        decode_byte(b, s);
        if (pin)
            pending_runs.push_back(pinned);
        else
            foreach (fresh_runs[k]) pending_runs.push_back(fresh_runs[k]);
    endtask

    task automatic read_pixels();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_IMAGE_PIXELS;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[LEN_W-1:0] !== image_pixels) begin
            if (bad_runs < 10)
                $display("image_pixels readback: exp %0d got %0d", image_pixels,
                         prdata[LEN_W-1:0]);
            bad_runs++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain the block, then write image_pixels and read it back
    task automatic set_pixels(input logic [LEN_W-1:0] v);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_IMAGE_PIXELS;
        pwdata  <= {{(CFG_DATA_W-LEN_W){1'b0}}, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        image_pixels = v;
        read_pixels();
    endtask

    // Mostly short runs, some around the pixel limit, a few huge ones
    function automatic int unsigned pick_len(input logic [LEN_W-1:0] pix);
        int unsigned roll;
        int unsigned v;
        roll = $urandom_range(99);
        if (roll < 50)
            v = $urandom_range(1, 8);
        else if (roll < 75)
            v = $urandom_range(9, 300);
        else if (roll < 85)
            v = 32'(pix) + $urandom_range(2) - 1;
        else if (roll < 95)
            v = $urandom_range(1, 65535);
        else
            v = 65535;
        if (v < 1)
            v = 1;
        if (v > 65535)
            v = 65535;
        return v;
    endfunction

    // Encode a segment: colour bit, gamma-coded runs, zero padding to a byte.
    // Now and then break it: an overlong zero prefix or a cut-off tail.
    task automatic send_segment(input logic [LEN_W-1:0] pix);
        bit          seg [$];
        int unsigned len;
        int unsigned nb;
        int unsigned roll;
        int unsigned cut;
        logic [7:0]  b;
        seg.push_back(1'($urandom_range(1)));
        repeat ($urandom_range(1, 6)) begin
            len = pick_len(pix);
            nb  = 0;
            while ((len >> nb) != 0) nb++;
            repeat (nb - 1) seg.push_back(1'b0);
            for (int k = nb - 1; k >= 0; k--) seg.push_back(len[k]);
        end
        roll = $urandom_range(99);
        if (roll < 10) begin
            repeat ($urandom_range(RUN_BITS, RUN_BITS + 8)) seg.push_back(1'b0);
        end else if (roll < 20) begin
            cut = $urandom_range(1, seg.size());
            while (seg.size() > cut) void'(seg.pop_back());
        end
        while (seg.size() % BYTE_BITS != 0) seg.push_back(1'b0);
        for (int k = 0; k < seg.size(); k += BYTE_BITS) begin
            for (int j = 0; j < BYTE_BITS; j++) b[j] = seg[k+j];
            send_byte(b, k == 0, 1'b0, NO_RUN);
        end
        if ($urandom_range(99) < 15)
            send_byte(8'($urandom), $urandom_range(3) == 0, 1'b0, NO_RUN);
    endtask

    // Receiver back-pressure
    always @(negedge i_clk)
        i_out_stall <= !calm && ($urandom_range(99) < STALL_PCT);

    // Check each run transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_run = '{colour: o_run_colour, length: o_run_length,
                        error: o_run_error, last: o_last_of_byte};
            if (pending_runs.size() == 0) begin
                if (bad_runs < 10)
                    $display("unexpected run: colour %0d len %0d err %0d last %0d",
                             got_run.colour, got_run.length, got_run.error, got_run.last);
                bad_runs++;
            end else begin
                want_run = pending_runs.pop_front();
                if (got_run.colour !== want_run.colour || got_run.length !== want_run.length ||
                    got_run.error !== want_run.error || got_run.last !== want_run.last) begin
                    if (bad_runs < 10)
                        $display("run mismatch: exp c%0d l%0d e%0d t%0d got c%0d l%0d e%0d t%0d",
                                 want_run.colour, want_run.length, want_run.error,
                                 want_run.last, got_run.colour, got_run.length,
                                 got_run.error, got_run.last);
                    bad_runs++;
                end
            end
        end
    end

    // Abort if no transaction of any kind moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT) begin
            $display("tb_elias_gamma_rle_bitmap_decoder_top NOT OK");
            $finish;
        end
    end

    initial begin
        logic [LEN_W-1:0] pix;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_data_byte     = '0;
        i_segment_start = 1'b0;
        i_out_stall     = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        bad_runs        = 0;
        phase_items     = 0;
        hang_cycles     = 0;
        calm            = 1'b0;
        image_pixels    = IMAGE_PIXELS_RST;
        dec_colour      = 1'b0;
        dec_skip        = 1'b0;
        clear_dec();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        read_pixels();

        // Directed part
        foreach (plan[r]) begin
            if (plan[r].wr_pix)
                set_pixels(plan[r].pix);
            send_byte(plan[r].data, plan[r].start, plan[r].pin, plan[r].run);
        end

        // Random segments under several pixel limits; one phase runs without gaps
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: pix = 16'd1;
                1: pix = LEN_W'($urandom_range(2, 40));
                2: pix = LEN_W'($urandom_range(41, 65534));
                3: pix = 16'hFFFF;
                default: pix = LEN_W'($urandom_range(100, 3000));
            endcase
            set_pixels(pix);
            calm = (ph == 3);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_segment(pix);
        end
        calm = 1'b0;

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_runs == 0)
            $display("tb_elias_gamma_rle_bitmap_decoder_top OK");
        else
            $display("tb_elias_gamma_rle_bitmap_decoder_top NOT OK");
        $finish;
    end

endmodule

/* sim.f */
hdl/egrd_pkg.sv
hdl/egrd_decode.sv
hdl/elias_gamma_rle_bitmap_decoder_top.sv
verif/tb_elias_gamma_rle_bitmap_decoder_top.sv
